// ----- rtl/ils_pkg.sv -----
// shared types and constants for the indexed list store
package ils_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    // fixed port widths
    localparam int REQ_BITS    = 2;
    localparam int POS_BITS    = 6;
    localparam int VALUE_BITS  = 32;
    localparam int LEN_BITS    = 7;
    localparam int STATUS_BITS = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what every cell does at each clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

endpackage

// ----- rtl/ils_cell.sv -----
// one entry cell of the list chain
module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IDX_W     = 6,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  cell_op_t             op,
    input  logic [IDX_W-1:0]     pos,
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] prev_data,
    input  logic [WORD_BITS-1:0] next_data,
    output logic [WORD_BITS-1:0] data,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 at_pos;
    logic                 above_pos;

    assign at_pos    = (pos == IDX_W'(IDX));
    assign above_pos = (IDX_W'(IDX) > pos);

    always_comb begin
        data_next = data_reg;
        unique case (op)
            CELL_HOLD: data_next = data_reg;
            CELL_WRITE: begin
                if (at_pos) data_next = word;
            end
            CELL_SHIFT_UP: begin
                if (above_pos) data_next = prev_data;
                else if (at_pos) data_next = word;
            end
            CELL_SHIFT_DOWN: begin
                if (above_pos || at_pos) data_next = next_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // masked so the top can or all cells together
    assign rd_data = at_pos ? data_reg : '0;

endmodule

// ----- rtl/indexed_list_store.sv -----
// top level of the indexed list store: request decode, cell chain, result register
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_req_type, s_position, s_item_value
//  m_       out  m_valid/m_ready    m_read_value, m_list_length, m_status
//
// one request per cycle unless the input is stalled; every cell of the chain moves at once on the
// accepting edge, and the result register loads on that same edge, so the beat is offered next cycle
// the next request sees the list left by the previous one with no gap
// a held result only stalls the input when m_ready is low
// aresetn empties the list; entry contents are not cleared
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [REQ_BITS-1:0]    s_req_type,
    input  logic [POS_BITS-1:0]    s_position,
    input  logic [VALUE_BITS-1:0]  s_item_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_BITS-1:0]  m_read_value,
    output logic [LEN_BITS-1:0]    m_list_length,
    output logic [STATUS_BITS-1:0] m_status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [VALUE_BITS-1:0]  rd_val_reg;
    logic [VALUE_BITS-1:0]  rd_val_next;
    logic [LEN_BITS-1:0]    len_reg;
    logic [LEN_BITS-1:0]    len_next;
    status_t                status_reg;
    status_t                status_next;

    logic                   accept;
    logic                   full;
    logic                   in_range;
    logic                   take_read;
    req_t                   req;
    cell_op_t               op;
    logic [IDX_W-1:0]       cell_pos;
    logic [CMP_W-1:0]       pos_cmp;
    logic [CMP_W-1:0]       cnt_cmp;
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   cell_data [CAPACITY];
    logic [WORD_BITS-1:0]   cell_rd   [CAPACITY];
    logic [WORD_BITS-1:0]   rd_or;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign req      = req_t'(s_req_type);
    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign pos_cmp  = CMP_W'(s_position);
    assign cnt_cmp  = CMP_W'(cnt_reg);
    assign in_range = (pos_cmp < cnt_cmp);
    assign word     = WORD_BITS'(s_item_value);

    always_comb begin
        op          = CELL_HOLD;
        cell_pos    = IDX_W'(pos_cmp);
        cnt_next    = cnt_reg;
        status_next = ST_OK;
        take_read   = 1'b0;
        unique case (req)
            REQ_APPEND: begin
                cell_pos = IDX_W'(cnt_reg);
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op       = CELL_WRITE;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            REQ_INSERT: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op       = CELL_SHIFT_UP;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    op        = CELL_SHIFT_DOWN;
                    take_read = 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            REQ_READ: begin
                if (!in_range) status_next = ST_RANGE;
                else take_read = 1'b1;
            end
            default: status_next = ST_OK;
        endcase
        if (!accept) begin
            op       = CELL_HOLD;
            cnt_next = cnt_reg;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] prev_d;
        logic [WORD_BITS-1:0] next_d;
        if (i == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_inner
            assign next_d = cell_data[i+1];
        end
        ils_cell #(
            .IDX       (i),
            .IDX_W     (IDX_W),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .pos       (cell_pos),
            .word      (word),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .rd_data   (cell_rd[i])
        );
    end

    // only the addressed cell drives a nonzero word
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        rd_val_next  = rd_val_reg;
        len_next     = len_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            rd_val_next  = take_read ? VALUE_BITS'(rd_or) : '0;
            len_next     = LEN_BITS'(cnt_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_val_reg <= rd_val_next;
        len_reg    <= len_next;
        if (accept) status_reg <= status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = rd_val_reg;
    assign m_list_length = len_reg;
    assign m_status      = status_reg;

endmodule
